FILE: src/sfla_pkg.sv
`default_nettype none
package sfla_pkg;

  localparam int ARENA_BYTES = 4096;
  localparam int HEADER_BYTES = 12;
  localparam int OFS_W = 12;
  localparam int SIZE_W = 13;
  localparam int MAX_WALK = ARENA_BYTES / HEADER_BYTES + 2;
  localparam int STEP_W = $clog2(MAX_WALK + 1);

  localparam logic [OFS_W-1:0] HDR_OFS = OFS_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] HDR_SIZE = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] MIN_ARENA = SIZE_W'(2 * HEADER_BYTES);
  localparam logic [SIZE_W-1:0] MAX_ARENA = SIZE_W'(ARENA_BYTES);
  localparam logic [STEP_W-1:0] WALK_LIMIT = STEP_W'(MAX_WALK);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic CFG_FIT_MODE = 1'b0;
  localparam logic CFG_ARENA_SIZE = 1'b1;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NONE = 2'd3;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLR,
    DP_INIT,
    DP_LOAD,
    DP_A_HEAD,
    DP_A_READ,
    DP_A_EVAL,
    DP_A_W1,
    DP_A_W2,
    DP_A_W3,
    DP_F_CLAIM,
    DP_F_HEAD,
    DP_F_READ,
    DP_F_STEP,
    DP_F_NBRS,
    DP_F_PC,
    DP_F_PCW,
    DP_F_W1,
    DP_F_W2,
    DP_RESP
  } dp_op_t;

  typedef struct packed {
    logic in_cmd;
    logic fm_bad;
    logic walk_end;
    logic found;
    logic first_hit;
    logic split;
    logic free_bad;
    logic granted_hit;
    logic free_walk;
    logic clr_last;
    logic arena_wr;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: src/sfla_ctrl.sv
`default_nettype none
module sfla_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  sfla_pkg::dp_status_t  st,
  output sfla_pkg::dp_op_t      op
);
  import sfla_pkg::*;

  typedef enum logic [18:0] {
    S_CLEAR  = 19'h00001,
    S_INIT   = 19'h00002,
    S_IDLE   = 19'h00004,
    S_A_HEAD = 19'h00008,
    S_A_TEST = 19'h00010,
    S_A_EVAL = 19'h00020,
    S_A_W1   = 19'h00040,
    S_A_W2   = 19'h00080,
    S_A_W3   = 19'h00100,
    S_F_CHK  = 19'h00200,
    S_F_HEAD = 19'h00400,
    S_F_TEST = 19'h00800,
    S_F_STEP = 19'h01000,
    S_F_PC   = 19'h02000,
    S_F_PCW  = 19'h04000,
    S_F_W1   = 19'h08000,
    S_F_W2   = 19'h10000,
    S_DONE   = 19'h20000,
    S_SPARE  = 19'h40000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op = DP_NOP;
    unique case (state)
      S_CLEAR: begin
        op = DP_CLR;
        if (st.clr_last) state_next = S_INIT;
      end
      S_INIT: begin
        op = DP_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op = DP_LOAD;
          state_next = (st.in_cmd == CMD_FREE) ? S_F_CHK : S_A_HEAD;
        end
      end
      S_A_HEAD: begin
        op = DP_A_HEAD;
        state_next = st.fm_bad ? S_DONE : S_A_TEST;
      end
      S_A_TEST: begin
        if (st.walk_end) begin
          state_next = st.found ? S_A_W1 : S_DONE;
        end else begin
          op = DP_A_READ;
          state_next = S_A_EVAL;
        end
      end
      S_A_EVAL: begin
        op = DP_A_EVAL;
        state_next = st.first_hit ? S_A_W1 : S_A_TEST;
      end
      S_A_W1: begin
        op = DP_A_W1;
        state_next = S_A_W2;
      end
      S_A_W2: begin
        op = DP_A_W2;
        state_next = st.split ? S_A_W3 : S_DONE;
      end
      S_A_W3: begin
        op = DP_A_W3;
        state_next = S_DONE;
      end
      S_F_CHK: begin
        if (st.free_bad || !st.granted_hit) begin
          state_next = S_DONE;
        end else begin
          op = DP_F_CLAIM;
          state_next = S_F_HEAD;
        end
      end
      S_F_HEAD: begin
        op = DP_F_HEAD;
        state_next = S_F_TEST;
      end
      S_F_TEST: begin
        if (st.free_walk) begin
          op = DP_F_READ;
          state_next = S_F_STEP;
        end else begin
          op = DP_F_NBRS;
          state_next = S_F_PC;
        end
      end
      S_F_STEP: begin
        op = DP_F_STEP;
        state_next = S_F_TEST;
      end
      S_F_PC: begin
        op = DP_F_PC;
        state_next = S_F_PCW;
      end
      S_F_PCW: begin
        op = DP_F_PCW;
        state_next = S_F_W1;
      end
      S_F_W1: begin
        op = DP_F_W1;
        state_next = S_F_W2;
      end
      S_F_W2: begin
        op = DP_F_W2;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          op = DP_RESP;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
    // A new arena size throws away the list and starts the clearing pass over.
    if (st.arena_wr) begin
      op = DP_NOP;
      state_next = S_CLEAR;
    end
  end

endmodule
`default_nettype wire

FILE: src/sfla_dp.sv
`default_nettype none
module sfla_dp (
  input  wire                          clk,
  input  wire                          rst,
  input  sfla_pkg::dp_op_t             op,
  output sfla_pkg::dp_status_t         st,
  input  wire                          cfg_we,
  input  wire                          cfg_index,
  input  wire  [sfla_pkg::SIZE_W-1:0]  cfg_data,
  input  wire                          cmd,
  input  wire  [sfla_pkg::SIZE_W-1:0]  req_size,
  input  wire  [sfla_pkg::OFS_W-1:0]   addr,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         status,
  output logic [sfla_pkg::OFS_W-1:0]   addr_out
);
  import sfla_pkg::*;

  logic [SIZE_W-1:0] bs_mem [ARENA_BYTES];
  logic [OFS_W-1:0]  nf_mem [ARENA_BYTES];
  logic              gr_mem [ARENA_BYTES];

  logic [OFS_W-1:0]  bs_ra, nf_ra, gr_ra, bs_wa, nf_wa, gr_wa;
  logic [SIZE_W-1:0] bs_rd, bs_wd;
  logic [OFS_W-1:0]  nf_rd, nf_wd;
  logic              gr_rd, gr_wd;
  logic              bs_we, nf_we, gr_we;

  logic [1:0]        fit_mode;
  logic [SIZE_W-1:0] arena;
  logic [OFS_W-1:0]  clr_cnt;

  logic              cmd_r, found;
  logic [SIZE_W-1:0] req_r, pick_size, tsize, psize, csize;
  logic [OFS_W-1:0]  t_r, prev, cur, pick_prev, pick_cur, pick_next, cnext;
  logic [STEP_W-1:0] steps;

  logic [SIZE_W:0]   req_hdr, rest;
  logic              fit_ok, take, whole, left, right, arena_wr;
  logic [OFS_W-1:0]  nn, t_in;
  logic [SIZE_W-1:0] arena_clamped, left_sum, right_sum;

  assign arena_wr = cfg_we && (cfg_index == CFG_ARENA_SIZE);
  assign t_in = addr - HDR_OFS;

  assign req_hdr = {1'b0, req_r} + {1'b0, HDR_SIZE};
  assign fit_ok = {1'b0, bs_rd} >= req_hdr;
  always_comb begin
    unique case (fit_mode)
      FIT_FIRST: take = fit_ok && !found;
      FIT_BEST:  take = fit_ok && (!found || pick_size >= bs_rd);
      FIT_WORST: take = fit_ok && (!found || pick_size <= bs_rd);
      FIT_NONE:  take = 1'b0;
    endcase
  end

  assign rest = {1'b0, pick_size} - req_hdr;
  assign whole = rest < {1'b0, HDR_SIZE};
  assign nn = pick_cur + req_hdr[OFS_W-1:0];

  assign left = ({1'b0, prev} + psize) == {1'b0, t_r};
  assign right = (cur != '0) && (({1'b0, t_r} + tsize) == {1'b0, cur});
  assign left_sum = psize + tsize + (right ? csize : '0);
  assign right_sum = tsize + csize;

  always_comb begin
    if (cfg_data < MIN_ARENA) arena_clamped = MIN_ARENA;
    else if (cfg_data > MAX_ARENA) arena_clamped = MAX_ARENA;
    else arena_clamped = cfg_data;
  end

  always_comb begin
    st.in_cmd = cmd;
    st.fm_bad = (fit_mode == FIT_NONE);
    st.walk_end = (cur == '0) || (steps >= WALK_LIMIT);
    st.found = found;
    st.first_hit = take && (fit_mode == FIT_FIRST);
    st.split = !whole;
    st.free_bad = (t_r < HDR_OFS) || ({1'b0, t_r} >= arena);
    st.granted_hit = gr_rd;
    st.free_walk = (cur != '0) && (prev >= t_r || t_r >= cur) && (steps < WALK_LIMIT);
    st.clr_last = (clr_cnt == '1);
    st.arena_wr = arena_wr;
    st.out_free = !out_valid || !out_stall;
  end

  always_comb begin
    bs_ra = cur;
    nf_ra = cur;
    gr_ra = t_in;
    bs_we = 1'b0;
    nf_we = 1'b0;
    gr_we = 1'b0;
    bs_wa = clr_cnt;
    nf_wa = clr_cnt;
    gr_wa = clr_cnt;
    bs_wd = '0;
    nf_wd = '0;
    gr_wd = 1'b0;
    unique case (op)
      DP_CLR: begin
        bs_we = 1'b1;
        nf_we = 1'b1;
        gr_we = 1'b1;
      end
      DP_INIT: begin
        nf_we = 1'b1;
        nf_wa = '0;
        nf_wd = HDR_OFS;
        bs_we = 1'b1;
        bs_wa = HDR_OFS;
        bs_wd = arena - HDR_SIZE;
      end
      DP_LOAD: begin
        nf_ra = '0;
      end
      DP_A_W1: begin
        nf_we = 1'b1;
        nf_wa = pick_prev;
        nf_wd = whole ? pick_next : nn;
        bs_we = 1'b1;
        bs_wa = pick_cur;
        bs_wd = whole ? pick_size : req_hdr[SIZE_W-1:0];
        gr_we = 1'b1;
        gr_wa = pick_cur;
        gr_wd = 1'b1;
      end
      DP_A_W2: begin
        nf_we = 1'b1;
        nf_wa = pick_cur;
        nf_wd = '0;
        bs_we = !whole;
        bs_wa = nn;
        bs_wd = rest[SIZE_W-1:0];
      end
      DP_A_W3: begin
        nf_we = 1'b1;
        nf_wa = nn;
        nf_wd = pick_next;
      end
      DP_F_CLAIM: begin
        gr_we = 1'b1;
        gr_wa = t_r;
        gr_wd = 1'b0;
        nf_ra = '0;
        bs_ra = t_r;
      end
      DP_F_NBRS: begin
        bs_ra = prev;
      end
      DP_F_W1: begin
        nf_we = 1'b1;
        nf_wa = t_r;
        nf_wd = (right && !left) ? cnext : cur;
        bs_we = left || right;
        bs_wa = left ? prev : t_r;
        bs_wd = left ? left_sum : right_sum;
      end
      DP_F_W2: begin
        nf_we = 1'b1;
        nf_wa = prev;
        nf_wd = left ? (right ? cnext : cur) : t_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (bs_we) bs_mem[bs_wa] <= bs_wd;
    if (nf_we) nf_mem[nf_wa] <= nf_wd;
    if (gr_we) gr_mem[gr_wa] <= gr_wd;
    bs_rd <= bs_mem[bs_ra];
    nf_rd <= nf_mem[nf_ra];
    gr_rd <= gr_mem[gr_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= FIT_FIRST;
      arena <= MAX_ARENA;
      clr_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_FIT_MODE) fit_mode <= cfg_data[1:0];
      if (arena_wr) arena <= arena_clamped;
      if (arena_wr) clr_cnt <= '0;
      else if (op == DP_CLR) clr_cnt <= clr_cnt + 1'b1;
      if (op == DP_RESP) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      DP_LOAD: begin
        cmd_r <= cmd;
        req_r <= req_size;
        t_r <= t_in;
        prev <= '0;
        steps <= '0;
        found <= 1'b0;
      end
      DP_A_HEAD: cur <= nf_rd;
      DP_A_EVAL: begin
        if (take) begin
          found <= 1'b1;
          pick_prev <= prev;
          pick_cur <= cur;
          pick_size <= bs_rd;
          pick_next <= nf_rd;
        end
        prev <= cur;
        cur <= nf_rd;
        steps <= steps + 1'b1;
      end
      DP_F_HEAD: begin
        cur <= nf_rd;
        tsize <= bs_rd;
      end
      DP_F_STEP: begin
        prev <= cur;
        cur <= nf_rd;
        steps <= steps + 1'b1;
      end
      DP_F_PC: begin
        psize <= bs_rd;
        cnext <= nf_rd;
      end
      DP_F_PCW: csize <= bs_rd;
      DP_RESP: begin
        status <= (cmd_r == CMD_ALLOC) && !found;
        addr_out <= ((cmd_r == CMD_ALLOC) && found) ? (pick_cur + HDR_OFS) : '0;
      end
      default: begin
      end
    endcase
  end

  a_grant_fits: assert property (@(posedge clk) disable iff (rst)
    (op == DP_A_W1) |-> (found && ({1'b0, pick_size} >= req_hdr) && (pick_cur >= HDR_OFS)))
    else $error("granted block does not hold the request");

  a_free_in_arena: assert property (@(posedge clk) disable iff (rst)
    (op == DP_F_W1) |-> ((t_r >= HDR_OFS) && ({1'b0, t_r} < arena)))
    else $error("free relinks a block outside the arena");

  a_alloc_write_order: assert property (@(posedge clk) disable iff (rst)
    (op == DP_A_W2) |-> ($past(op) == DP_A_W1))
    else $error("allocate write sequence out of order");

endmodule
`default_nettype wire

FILE: src/sorted_free_list_allocator.sv
`default_nettype none
// Address-ordered free-list allocator over a byte arena of up to 4096 bytes, with a
// 12-byte header per block and first, best or worst fit chosen by fit_mode. One request
// is worked at a time and every request gets exactly one result. An allocate walks the
// free blocks (first fit stops at the first block that fits); a free walks the free
// blocks below the freed one. The walk rate is set by the single read port of the size
// and link memories. After reset and after every arena_size write a clearing pass runs
// over all 4096 entries of the memories, during which no request is taken.
module sorted_free_list_allocator (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire                          cfg_index,
  input  wire  [sfla_pkg::SIZE_W-1:0]  cfg_data,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          cmd,
  input  wire  [sfla_pkg::SIZE_W-1:0]  req_size,
  input  wire  [sfla_pkg::OFS_W-1:0]   addr,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         status,
  output logic [sfla_pkg::OFS_W-1:0]   addr_out
);
  import sfla_pkg::*;

  dp_op_t     op;
  dp_status_t st;

  sfla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .op       (op)
  );

  sfla_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .req_size  (req_size),
    .addr      (addr),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .addr_out  (addr_out)
  );

endmodule
`default_nettype wire

FILE: dv/sorted_free_list_allocator_checker.sv
`timescale 1ns / 100ps
module sorted_free_list_allocator_checker (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_we,
  input  wire                         cfg_index,
  input  wire  [sfla_pkg::SIZE_W-1:0] cfg_data,
  input  wire                         in_valid,
  input  wire                         in_stall,
  input  wire                         cmd,
  input  wire  [sfla_pkg::SIZE_W-1:0] req_size,
  input  wire  [sfla_pkg::OFS_W-1:0]  addr,
  input  wire                         out_valid,
  input  wire                         out_stall,
  input  wire                         status,
  input  wire  [sfla_pkg::OFS_W-1:0]  addr_out,
  output int                          fails,
  output int                          pending
);
  import sfla_pkg::*;

  typedef struct packed {
    logic             no_fit;
    logic [OFS_W-1:0] ofs;
  } grant_t;

  logic [SIZE_W-1:0] blk_size [ARENA_BYTES];
  logic [OFS_W-1:0]  link     [ARENA_BYTES];
  bit                in_use   [ARENA_BYTES];
  logic [1:0]        fit_sel;
  int                arena_len;
  grant_t            grant_q [$];

  function automatic int wrap(int o);
    return o % ARENA_BYTES;
  endfunction

  function automatic void rebuild_list();
    for (int i = 0; i < ARENA_BYTES; i++) begin
      blk_size[i] = '0;
      link[i] = '0;
      in_use[i] = 1'b0;
    end
    link[0] = HDR_OFS;
    blk_size[HEADER_BYTES] = SIZE_W'(arena_len - HEADER_BYTES);
  endfunction

  function automatic int clamp_len(int v);
    if (v < 2 * HEADER_BYTES) return 2 * HEADER_BYTES;
    if (v > ARENA_BYTES) return ARENA_BYTES;
    return v;
  endfunction

  function automatic grant_t grant_block(int req);
    int prev, cur, steps, sz, pprev, pcur, psize, give, nn;
    bit found, take;
    grant_t g;
    g = '{no_fit: 1'b1, ofs: '0};
    prev = 0;
    cur = link[0];
    steps = 0;
    found = 0;
    pprev = 0;
    pcur = 0;
    psize = 0;
    if (fit_sel == FIT_NONE) return g;
    while (cur != 0 && steps < MAX_WALK) begin
      sz = blk_size[wrap(cur)];
      if (req + HEADER_BYTES <= sz) begin
        case (fit_sel)
          FIT_FIRST: take = !found;
          FIT_BEST:  take = !found || psize >= sz;
          default:   take = !found || psize <= sz;
        endcase
        if (take) begin
          found = 1;
          pprev = prev;
          pcur = cur;
          psize = sz;
          if (fit_sel == FIT_FIRST) break;
        end
      end
      prev = cur;
      cur = link[wrap(cur)];
      steps++;
    end
    if (!found) return g;
    // A remainder too small to carry a header goes out with the block.
    give = (psize - req - HEADER_BYTES < HEADER_BYTES) ? psize - HEADER_BYTES : req;
    if (give + HEADER_BYTES == psize) begin
      link[wrap(pprev)] = link[wrap(pcur)];
    end else begin
      nn = pcur + give + HEADER_BYTES;
      blk_size[wrap(nn)] = SIZE_W'(psize - give - HEADER_BYTES);
      link[wrap(nn)] = link[wrap(pcur)];
      link[wrap(pprev)] = OFS_W'(nn);
    end
    blk_size[wrap(pcur)] = SIZE_W'(give + HEADER_BYTES);
    link[wrap(pcur)] = '0;
    in_use[wrap(pcur)] = 1'b1;
    g.no_fit = 1'b0;
    g.ofs = OFS_W'(pcur + HEADER_BYTES);
    return g;
  endfunction

  function automatic void release_block(int a);
    int t, prev, cur, steps, tsz, psz, keep;
    bit merged_left;
    t = (a + ARENA_BYTES - HEADER_BYTES) % ARENA_BYTES;
    if (t < HEADER_BYTES || t >= arena_len || !in_use[t]) return;
    in_use[t] = 1'b0;
    prev = 0;
    cur = link[0];
    steps = 0;
    merged_left = 0;
    while (cur != 0 && (prev >= t || t >= cur) && steps < MAX_WALK) begin
      prev = cur;
      cur = link[wrap(cur)];
      steps++;
    end
    tsz = blk_size[t];
    psz = blk_size[wrap(prev)];
    link[t] = OFS_W'(cur);
    link[wrap(prev)] = OFS_W'(t);
    if (prev + psz == t) begin
      merged_left = 1;
      blk_size[wrap(prev)] = SIZE_W'(psz + tsz);
      link[wrap(prev)] = OFS_W'(cur);
    end
    if (cur != 0 && t + tsz == cur) begin
      keep = merged_left ? prev : t;
      blk_size[wrap(keep)] = SIZE_W'(blk_size[wrap(keep)] + blk_size[wrap(cur)]);
      link[wrap(keep)] = link[wrap(cur)];
    end
  endfunction

  always @(posedge clk) begin
    grant_t got, want;
    if (rst) begin
      fit_sel = FIT_FIRST;
      arena_len = clamp_len(ARENA_BYTES);
      rebuild_list();
      grant_q.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FIT_MODE) begin
          fit_sel = cfg_data[1:0];
        end else begin
          arena_len = clamp_len(int'(cfg_data));
          rebuild_list();
        end
      end
      if (out_valid && !out_stall) begin
        got = '{no_fit: status, ofs: addr_out};
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d addr_out=%0d", $time, status,
                   addr_out);
          fails++;
        end else begin
          want = grant_q.pop_front();
          if (got.no_fit !== want.no_fit) begin
            $display("%0t: status mismatch expected %0d actual %0d", $time, want.no_fit,
                     got.no_fit);
            fails++;
          end
          if (got.ofs !== want.ofs) begin
            $display("%0t: addr_out mismatch expected %0d actual %0d", $time, want.ofs,
                     got.ofs);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (cmd == CMD_ALLOC) begin
          grant_q.push_back(grant_block(int'(req_size)));
        end else begin
          release_block(int'(addr));
          grant_q.push_back('{no_fit: 1'b0, ofs: '0});
        end
      end
    end
    pending = grant_q.size();
  end

endmodule

FILE: dv/sorted_free_list_allocator_tb.sv
`timescale 1ns / 100ps
module sorted_free_list_allocator_tb;
  import sfla_pkg::*;

  localparam int CYCLE_LIMIT = 6000000;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic              cfg_index;
  logic [SIZE_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic              cmd;
  logic [SIZE_W-1:0] req_size;
  logic [OFS_W-1:0]  addr;
  logic              out_valid;
  logic              out_stall;
  logic              status;
  logic [OFS_W-1:0]  addr_out;
  int                fails;
  int                pending;
  int                cycles;
  bit                quiet;
  int                hold_cnt;
  logic [OFS_W-1:0]  live_ofs [$];

  sorted_free_list_allocator i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .req_size(req_size),
    .addr(addr), .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .addr_out(addr_out)
  );

  sorted_free_list_allocator_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .req_size(req_size),
    .addr(addr), .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .addr_out(addr_out), .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || quiet) begin
      hold_cnt = 0;
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      hold_cnt = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Granted offsets feed the well-formed frees; free requests always answer zero.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall && !status && addr_out != 0) begin
      live_ofs.push_back(addr_out);
    end
  end

  task automatic send_request(logic c, logic [SIZE_W-1:0] r, logic [OFS_W-1:0] a);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    req_size <= r;
    addr <= a;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [SIZE_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ARENA_SIZE) live_ofs.delete();
  endtask

  task automatic random_request();
    int pick;
    logic [SIZE_W-1:0] r;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) r = $urandom_range(0, 64);
      else if (pick < 90) r = $urandom_range(0, 600);
      else if (pick < 98) r = $urandom_range(0, 4096);
      else r = $urandom_range(0, 8191);
      send_request(CMD_ALLOC, r, OFS_W'($urandom()));
    end else if (pick < 90 && live_ofs.size() > 0) begin
      pick = $urandom_range(0, live_ofs.size() - 1);
      send_request(CMD_FREE, SIZE_W'($urandom()), live_ofs[pick]);
      live_ofs.delete(pick);
    end else begin
      send_request(CMD_FREE, SIZE_W'($urandom()), OFS_W'($urandom()));
    end
  endtask

  initial begin
    logic [1:0]        fit_list [10];
    logic [SIZE_W-1:0] len_list [10];
    rst = 1'b1;
    cycles = 0;
    quiet = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FIT_MODE;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = CMD_ALLOC;
    req_size = '0;
    addr = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset arena, first fit.
    send_request(CMD_ALLOC, 0, 0);
    send_request(CMD_ALLOC, 4096, 0);
    send_request(CMD_ALLOC, 8191, 0);
    send_request(CMD_FREE, 0, 12'hFFF);
    send_request(CMD_FREE, 0, 0);
    send_request(CMD_FREE, 0, 24);
    send_request(CMD_FREE, 0, 24);
    // The last 12-byte block sits at 4084, so its data offset wraps to zero.
    send_request(CMD_ALLOC, 4060, 0);
    send_request(CMD_ALLOC, 0, 0);
    send_request(CMD_FREE, 0, 0);
    send_request(CMD_FREE, 0, 24);
    send_request(CMD_ALLOC, 4072, 0);
    send_request(CMD_ALLOC, 4071, 0);
    send_request(CMD_FREE, 0, 24);
    send_request(CMD_ALLOC, 40, 0);
    send_request(CMD_ALLOC, 100, 0);
    send_request(CMD_ALLOC, 20, 0);
    send_request(CMD_ALLOC, 20, 0);
    send_request(CMD_FREE, 0, 76);
    send_request(CMD_FREE, 0, 24);
    send_request(CMD_FREE, 0, 220);
    send_request(CMD_FREE, 0, 188);
    write_reg(CFG_FIT_MODE, SIZE_W'(FIT_NONE));
    send_request(CMD_ALLOC, 0, 0);
    send_request(CMD_ALLOC, 50, 0);

    fit_list = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_BEST, FIT_WORST, FIT_FIRST,
                 FIT_NONE, FIT_BEST, FIT_WORST, FIT_FIRST};
    len_list = '{4096, 4096, 4096, 24, 0, 8191, 300, 5000, 13'($urandom_range(100, 900)),
                 13'($urandom_range(24, 4096))};
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_FIT_MODE, SIZE_W'(fit_list[ph]));
      write_reg(CFG_ARENA_SIZE, len_list[ph]);
      if (ph == 9) quiet = 1'b1;
      repeat (ph == 6 ? 40 : 210) random_request();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sorted_free_list_allocator.f
src/sfla_pkg.sv
src/sfla_ctrl.sv
src/sfla_dp.sv
src/sorted_free_list_allocator.sv
dv/sorted_free_list_allocator_checker.sv
dv/sorted_free_list_allocator_tb.sv
